[rtl/ibcc_pkg.sv]
// ----------------------------------------------------------------------------
// ibcc_pkg
// Shared types and constants of the interval booking capacity check unit.
// ----------------------------------------------------------------------------
package ibcc_pkg;

	localparam int unsigned DAY_W      = 10;
	localparam int unsigned AMOUNT_W   = 16;
	localparam int unsigned CAP_W      = 16;
	localparam int unsigned SUM_W      = 32;
	localparam int unsigned COUNT_W    = 16;
	localparam int unsigned NUM_DAYS_W = 11;
	localparam int unsigned APB_AW     = 2;
	localparam int unsigned APB_DW     = 32;

	localparam logic [COUNT_W-1:0]    COUNT_LIMIT    = 16'd32767;
	localparam logic [NUM_DAYS_W-1:0] NUM_DAYS_RESET = 11'd1024;
	localparam logic [APB_AW-1:0]     ADDR_NUM_DAYS  = 2'd0;

	localparam logic [1:0] OP_LOAD_CAP = 2'd0;
	localparam logic [1:0] OP_RESERVE  = 2'd1;
	localparam logic [1:0] OP_EVALUATE = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RES_HI,
		ST_RES_LO,
		ST_SCAN,
		ST_DRAIN,
		ST_REPORT
	} state_t;

	typedef enum logic [1:0] {
		WR_ADD,
		WR_SUB,
		WR_ZERO
	} wr_op_t;

	typedef struct packed {
		logic   rd;
		logic   wr;
		logic   fwd;
		wr_op_t wr_op;
	} dmem_cmd_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic counted;
	} scan_cmd_t;

endpackage

[rtl/ibcc_delta_store.sv]
// ----------------------------------------------------------------------------
// ibcc_delta_store
// Difference memory with read-modify-write datapath and write bypass.
// ----------------------------------------------------------------------------
module ibcc_delta_store import ibcc_pkg::*; #(
	parameter int unsigned MAX_DAYS = 1024,
	parameter int unsigned DW       = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dmem_cmd_t           cmd,
	input  logic [DW-1:0]       raddr,
	input  logic [DW-1:0]       waddr,
	input  logic [AMOUNT_W-1:0] amount,
	output logic [SUM_W-1:0]    rdata
);

	logic [SUM_W-1:0] mem [0:MAX_DAYS];
	logic [SUM_W-1:0] rd_q;
	logic [SUM_W-1:0] byp_data_q;
	logic             byp_q;
	logic [SUM_W-1:0] wdata;

	assign rdata = byp_q ? byp_data_q : rd_q;

	always_comb begin
		case (cmd.wr_op)
			WR_ADD:  wdata = rdata + SUM_W'(amount);
			WR_SUB:  wdata = rdata - SUM_W'(amount);
			default: wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rd_q       <= mem[raddr];
			byp_data_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (cmd.rd) begin
			byp_q <= cmd.fwd && cmd.wr && (raddr == waddr);
		end
	end

endmodule

[rtl/ibcc_scan.sv]
// ----------------------------------------------------------------------------
// ibcc_scan
// Capacity memory and running prefix sum compare of the evaluate sweep.
// ----------------------------------------------------------------------------
module ibcc_scan import ibcc_pkg::*; #(
	parameter int unsigned MAX_DAYS = 1024,
	parameter int unsigned AW       = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cap_we,
	input  logic [AW-1:0]    cap_waddr,
	input  logic [CAP_W-1:0] cap_wdata,
	input  logic [AW-1:0]    cap_raddr,
	input  scan_cmd_t        cmd,
	input  logic [SUM_W-1:0] delta,
	output logic             fail
);

	logic [CAP_W-1:0] cap_mem [MAX_DAYS];
	logic [CAP_W-1:0] cap_rd_q;
	scan_cmd_t        cmd_s1;
	logic [SUM_W-1:0] run_q;
	logic             fail_q;
	logic [SUM_W-1:0] sum;
	logic             over;

	assign sum  = (cmd_s1.first ? '0 : run_q) + delta;
	assign over = cmd_s1.counted && (sum > SUM_W'(cap_rd_q));
	assign fail = fail_q;

	always_ff @(posedge clk) begin
		if (cap_we) begin
			cap_mem[cap_waddr] <= cap_wdata;
		end
		if (cmd.valid) begin
			cap_rd_q <= cap_mem[cap_raddr];
		end
		if (cmd_s1.valid) begin
			run_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			fail_q <= 1'b0;
		end else begin
			cmd_s1 <= cmd;
			if (cmd_s1.valid) begin
				fail_q <= cmd_s1.first ? over : (fail_q | over);
			end
		end
	end

endmodule

[rtl/ibcc_ctrl.sv]
// ----------------------------------------------------------------------------
// ibcc_ctrl
// Sequencer: transaction decode, memory commands, sweeps, result register.
// ----------------------------------------------------------------------------
module ibcc_ctrl import ibcc_pkg::*; #(
	parameter int unsigned MAX_DAYS = 1024,
	parameter int unsigned DW       = 11,
	parameter int unsigned AW       = 10,
	parameter int unsigned CW       = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [NUM_DAYS_W-1:0] num_days,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [1:0]            op,
	input  logic [DAY_W-1:0]      cap_day,
	input  logic [DAY_W-1:0]      start_day,
	input  logic [DAY_W-1:0]      end_day,
	input  logic [AMOUNT_W-1:0]   amount,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic                  fits,
	output logic                  invalid_seen,
	input  logic                  fail,
	output dmem_cmd_t             dcmd,
	output logic [DW-1:0]         draddr,
	output logic [DW-1:0]         dwaddr,
	output logic [AMOUNT_W-1:0]   damount,
	output logic                  cap_we,
	output logic [AW-1:0]         cap_waddr,
	output logic [AW-1:0]         cap_raddr,
	output scan_cmd_t             scmd
);

	state_t               state_q, state_d;
	logic [DW-1:0]        day_q;
	logic [DW-1:0]        hi_addr_q;
	logic [DW-1:0]        lo_addr_q;
	logic [AMOUNT_W-1:0]  amount_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 invalid_q;
	logic                 out_valid_q;
	logic                 fits_q;
	logic                 inv_seen_q;
	logic [CW-1:0]        days_eff;
	logic                 acc;
	logic                 res_bad;
	logic                 cap_ok;
	logic                 last_day;
	logic                 out_free;

	assign days_eff   = (CW'(num_days) > CW'(MAX_DAYS)) ? CW'(MAX_DAYS) : CW'(num_days);
	assign item_ready = (state_q == ST_IDLE) || (state_q == ST_RES_LO);
	assign acc        = item_valid && item_ready;
	assign res_bad    = (start_day > end_day) || (CW'(end_day) >= days_eff) ||
	                    (count_q >= COUNT_LIMIT);
	assign cap_ok     = CW'(cap_day) < CW'(MAX_DAYS);
	assign last_day   = day_q == DW'(MAX_DAYS);
	assign out_free   = !out_valid_q || result_ready;

	assign result_valid = out_valid_q;
	assign fits         = fits_q;
	assign invalid_seen = inv_seen_q;
	assign damount      = amount_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			ST_CLEAR: begin
				if (last_day) state_d = ST_IDLE;
			end
			ST_IDLE, ST_RES_LO: begin
				state_d = ST_IDLE;
				if (acc) begin
					case (op)
						OP_RESERVE:  if (!res_bad) state_d = ST_RES_HI;
						OP_EVALUATE: state_d = ST_SCAN;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_RES_HI: begin
				state_d = ST_RES_LO;
			end
			ST_SCAN: begin
				if (last_day) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		dcmd      = '0;
		draddr    = day_q;
		dwaddr    = day_q;
		scmd      = '0;
		cap_raddr = AW'(day_q);
		cap_we    = 1'b0;
		cap_waddr = AW'(cap_day);
		unique case (state_q)
			ST_CLEAR: begin
				dcmd.wr    = 1'b1;
				dcmd.wr_op = WR_ZERO;
			end
			ST_RES_HI: begin
				dcmd.wr    = 1'b1;
				dcmd.wr_op = WR_ADD;
				dwaddr     = hi_addr_q;
				dcmd.rd    = 1'b1;
				draddr     = lo_addr_q;
			end
			ST_RES_LO: begin
				dcmd.wr    = 1'b1;
				dcmd.wr_op = WR_SUB;
				dcmd.fwd   = 1'b1;
				dwaddr     = lo_addr_q;
			end
			ST_SCAN: begin
				dcmd.rd       = 1'b1;
				dcmd.wr       = 1'b1;
				dcmd.wr_op    = WR_ZERO;
				scmd.valid    = 1'b1;
				scmd.first    = day_q == '0;
				scmd.counted  = CW'(day_q) < days_eff;
			end
			default: begin
				dcmd = '0;
			end
		endcase
		if (acc) begin
			case (op)
				OP_LOAD_CAP: cap_we = cap_ok;
				OP_RESERVE: begin
					if (!res_bad) begin
						dcmd.rd = 1'b1;
						draddr  = DW'(start_day);
					end
				end
				default: cap_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			day_q       <= '0;
			count_q     <= '0;
			invalid_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_CLEAR || state_q == ST_SCAN) && !last_day) begin
				day_q <= day_q + 1'b1;
			end else if (acc && op == OP_EVALUATE) begin
				day_q <= '0;
			end
			if (acc && op == OP_RESERVE) begin
				if (res_bad) begin
					invalid_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end else if (state_q == ST_REPORT && out_free) begin
				count_q   <= '0;
				invalid_q <= 1'b0;
			end
			if (state_q == ST_REPORT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && op == OP_RESERVE) begin
			hi_addr_q <= DW'(start_day);
			lo_addr_q <= DW'({1'b0, end_day} + 11'd1);
			amount_q  <= amount;
		end
		if (state_q == ST_REPORT && out_free) begin
			fits_q     <= !fail;
			inv_seen_q <= invalid_q;
		end
	end

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_LIMIT)
		else $error("reservation count above limit");

	a_res_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RES_HI) |=> (state_q == ST_RES_LO))
		else $error("reservation update did not complete");

	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT && out_free) |=> (count_q == '0 && !invalid_q && result_valid))
		else $error("batch not cleared at report");

	a_day_bound: assert property (@(posedge clk) disable iff (!arst_n)
		day_q <= DW'(MAX_DAYS))
		else $error("sweep pointer out of range");

endmodule

[rtl/interval_booking_capacity_check_unit.sv]
// ----------------------------------------------------------------------------
// interval_booking_capacity_check_unit
// Per-day capacity check of a batch of interval reservations.
// ----------------------------------------------------------------------------
// A load-capacity transaction stays in ST_IDLE. A reservation performs two
// read-modify-write updates of the difference memory, whose read port is
// registered, in ST_RES_HI and then ST_RES_LO; a following transaction is
// taken in ST_RES_LO. An evaluate transaction sweeps all MAX_DAYS+1 entries
// of the difference memory, summing and comparing against the capacity
// memory while zeroing each entry, then passes ST_DRAIN and ST_REPORT,
// waiting there for a free result register, before the next transaction
// is taken. After reset the difference memory is cleared by a sweep during
// which no transaction is accepted; register writes are taken at any time.
// Capacities read during evaluate must have been loaded first.
// ----------------------------------------------------------------------------
module interval_booking_capacity_check_unit import ibcc_pkg::*; #(
	parameter int unsigned MAX_DAYS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [1:0]          op,
	input  logic [DAY_W-1:0]    cap_day,
	input  logic [CAP_W-1:0]    capacity,
	input  logic [DAY_W-1:0]    start_day,
	input  logic [DAY_W-1:0]    end_day,
	input  logic [AMOUNT_W-1:0] amount,
	output logic                result_valid,
	input  logic                result_ready,
	output logic                fits,
	output logic                invalid_seen
);

	localparam int unsigned DW = $clog2(MAX_DAYS + 1);
	localparam int unsigned AW = $clog2(MAX_DAYS);
	localparam int unsigned CW = (DW > NUM_DAYS_W) ? DW : NUM_DAYS_W;

	logic [NUM_DAYS_W-1:0] num_days_q;
	dmem_cmd_t             dcmd;
	scan_cmd_t             scmd;
	logic [DW-1:0]         draddr;
	logic [DW-1:0]         dwaddr;
	logic [AMOUNT_W-1:0]   damount;
	logic [SUM_W-1:0]      delta;
	logic                  cap_we;
	logic [AW-1:0]         cap_waddr;
	logic [AW-1:0]         cap_raddr;
	logic                  fail;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_NUM_DAYS) ? APB_DW'(num_days_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_days_q <= NUM_DAYS_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_NUM_DAYS) begin
			num_days_q <= pwdata[NUM_DAYS_W-1:0];
		end
	end

	ibcc_ctrl #(
		.MAX_DAYS (MAX_DAYS),
		.DW       (DW),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.num_days     (num_days_q),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.cap_day      (cap_day),
		.start_day    (start_day),
		.end_day      (end_day),
		.amount       (amount),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.fits         (fits),
		.invalid_seen (invalid_seen),
		.fail         (fail),
		.dcmd         (dcmd),
		.draddr       (draddr),
		.dwaddr       (dwaddr),
		.damount      (damount),
		.cap_we       (cap_we),
		.cap_waddr    (cap_waddr),
		.cap_raddr    (cap_raddr),
		.scmd         (scmd)
	);

	ibcc_delta_store #(
		.MAX_DAYS (MAX_DAYS),
		.DW       (DW)
	) u_delta (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.raddr  (draddr),
		.waddr  (dwaddr),
		.amount (damount),
		.rdata  (delta)
	);

	ibcc_scan #(
		.MAX_DAYS (MAX_DAYS),
		.AW       (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap_we    (cap_we),
		.cap_waddr (cap_waddr),
		.cap_wdata (capacity),
		.cap_raddr (cap_raddr),
		.cmd       (scmd),
		.delta     (delta),
		.fail      (fail)
	);

endmodule
